[rtl/core/pfrl_pkg.sv]
package pfrl_pkg;

	typedef struct packed {
		logic        func;
		logic [15:0] frame_len;
		logic [15:0] ether_type;
		logic [3:0]  ip_version;
		logic [3:0]  header_words;
		logic [7:0]  ip_protocol;
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
		logic [15:0] l4_word;
		logic [63:0] now_ns;
		logic [7:0]  rule_action_in;
	} item_t;

	typedef struct packed {
		logic       verdict;
		logic [3:0] reason;
		logic       write_ok;
	} result_t;

	localparam logic [2:0] CFG_WINDOW = 3'd0;
	localparam logic [2:0] CFG_PORT_A = 3'd1;
	localparam logic [2:0] CFG_PORT_B = 3'd2;
	localparam logic [2:0] CFG_PORT_C = 3'd3;
	localparam logic [2:0] CFG_PORT_D = 3'd4;

	localparam logic [3:0] RSN_CLEAN    = 4'd0;
	localparam logic [3:0] RSN_SANITY   = 4'd1;
	localparam logic [3:0] RSN_RATE     = 4'd2;
	localparam logic [3:0] RSN_RULE     = 4'd3;
	localparam logic [3:0] RSN_SYN      = 4'd4;
	localparam logic [3:0] RSN_NULL     = 4'd5;
	localparam logic [3:0] RSN_ECHO     = 4'd6;
	localparam logic [3:0] RSN_UDP      = 4'd7;
	localparam logic [3:0] RSN_L4_SHORT = 4'd8;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic clear_step;
		logic capture;
		logic decide;
	} ctrl_t;

	typedef struct packed {
		logic clear_done;
	} stat_t;

endpackage

[rtl/core/pfrl_ctrl.sv]
module pfrl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pfrl_pkg::stat_t stat,
	output pfrl_pkg::ctrl_t ctrl
);
	import pfrl_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				ctrl.clear_step = 1'b1;
				if (stat.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.capture = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				ctrl.decide = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.capture |=> ##1 ctrl.decide)
		else $error("decide did not follow capture");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.decide |=> !busy)
		else $error("not idle after decide");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.capture && ctrl.clear_step))
		else $error("capture during clear");

endmodule

[rtl/core/pfrl_datapath.sv]
module pfrl_datapath #(
	parameter int RATE_SETS = 1024,
	parameter int RATE_WAYS = 4,
	parameter int RULE_SETS = 256,
	parameter int RULE_WAYS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pfrl_pkg::ctrl_t   ctrl,
	output pfrl_pkg::stat_t   stat,
	input  pfrl_pkg::item_t   item,
	input  logic [39:0]       window,
	input  logic [15:0]       port_a,
	input  logic [15:0]       port_b,
	input  logic [15:0]       port_c,
	input  logic [15:0]       port_d,
	output logic              result_valid,
	output pfrl_pkg::result_t result
);
	import pfrl_pkg::*;

	localparam int RSB = (RATE_SETS > 1) ? $clog2(RATE_SETS) : 1;
	localparam int RWB = (RATE_WAYS > 1) ? $clog2(RATE_WAYS) : 1;
	localparam int USB = (RULE_SETS > 1) ? $clog2(RULE_SETS) : 1;
	localparam int UWB = (RULE_WAYS > 1) ? $clog2(RULE_WAYS) : 1;
	localparam int CSETS = (RATE_SETS > RULE_SETS) ? RATE_SETS : RULE_SETS;
	localparam int CB = $clog2(CSETS + 1);

	// One memory row per set: all ways side by side.
	typedef struct packed {
		logic [31:0] key;
		logic [63:0] stamp;
	} rate_ent_t;
	typedef struct packed {
		logic [31:0] key;
		logic [7:0]  act;
	} rule_ent_t;

	rate_ent_t [RATE_WAYS-1:0] rate_mem [RATE_SETS];
	logic [RATE_WAYS-1:0] rate_vmem [RATE_SETS];
	logic [RATE_WAYS-1:0][RWB-1:0] lru_mem [RATE_SETS];
	rule_ent_t [RULE_WAYS-1:0] rule_mem [RULE_SETS];
	logic [RULE_WAYS-1:0] rule_vmem [RULE_SETS];

	rate_ent_t [RATE_WAYS-1:0] rate_rd_s1;
	logic [RATE_WAYS-1:0] rate_v_s1;
	logic [RATE_WAYS-1:0][RWB-1:0] lru_s1;
	rule_ent_t [RULE_WAYS-1:0] rule_rd_s1;
	logic [RULE_WAYS-1:0] rule_v_s1;
	item_t item_q;
	logic [CB-1:0] clr_q;

	logic [RSB-1:0] rset_q;
	logic [USB-1:0] uset_q;

	function automatic logic [RSB-1:0] rate_idx(input logic [31:0] k);
		logic [63:0] m;
		m = 64'(k) % 64'(RATE_SETS);
		return m[RSB-1:0];
	endfunction
	function automatic logic [USB-1:0] rule_idx(input logic [31:0] k);
		logic [63:0] m;
		m = 64'(k) % 64'(RULE_SETS);
		return m[USB-1:0];
	endfunction

	assign rset_q = rate_idx(item_q.source_addr);
	assign uset_q = rule_idx(item_q.dest_addr);

	assign stat.clear_done = (clr_q == CB'(CSETS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctrl.clear_step && !stat.clear_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			item_q <= item;
		end
	end

	// Read stage.
	always_ff @(posedge clk) begin
		rate_rd_s1 <= rate_mem[rset_q];
		rate_v_s1  <= rate_vmem[rset_q];
		lru_s1     <= lru_mem[rset_q];
		rule_rd_s1 <= rule_mem[uset_q];
		rule_v_s1  <= rule_vmem[uset_q];
	end

	// Lookup and decision.
	logic r_hit, r_free, u_hit, u_free;
	logic [RWB-1:0] r_hw, r_fw, r_way;
	logic [UWB-1:0] u_hw, u_fw, u_way;
	logic [63:0] age;
	logic in_window;
	logic [16:0] tcp_end, small_end;
	logic [3:0] l4r;
	logic sane, rate_wr, rule_wr;
	logic [RATE_WAYS-1:0][RWB-1:0] lru_new;
	logic [RWB-1:0] pos;
	result_t res;
	logic rule_drop;

	always_comb begin
		r_hit = 1'b0; r_hw = '0; r_free = 1'b0; r_fw = '0;
		for (int w = 0; w < RATE_WAYS; w++) begin
			if (rate_v_s1[w] && rate_rd_s1[w].key == item_q.source_addr) begin
				r_hit = 1'b1; r_hw = RWB'(w);
			end
		end
		for (int w = RATE_WAYS - 1; w >= 0; w--) begin
			if (!rate_v_s1[w]) begin
				r_free = 1'b1; r_fw = RWB'(w);
			end
		end
		r_way = r_hit ? r_hw : (r_free ? r_fw : lru_s1[0]);
		age = item_q.now_ns - rate_rd_s1[r_hw].stamp;
		in_window = r_hit && (age < {24'd0, window});

		pos = '0;
		for (int k = 0; k < RATE_WAYS; k++) begin
			if (lru_s1[k] == r_way) pos = RWB'(k);
		end
		for (int k = 0; k < RATE_WAYS - 1; k++) begin
			lru_new[k] = (RWB'(k) >= pos) ? lru_s1[k + 1] : lru_s1[k];
		end
		lru_new[RATE_WAYS-1] = r_way;

		u_hit = 1'b0; u_hw = '0; u_free = 1'b0; u_fw = '0;
		for (int w = 0; w < RULE_WAYS; w++) begin
			if (rule_v_s1[w] && rule_rd_s1[w].key == item_q.dest_addr && !u_hit) begin
				u_hit = 1'b1; u_hw = UWB'(w);
			end
		end
		for (int w = RULE_WAYS - 1; w >= 0; w--) begin
			if (!rule_v_s1[w]) begin
				u_free = 1'b1; u_fw = UWB'(w);
			end
		end
		u_way = u_hit ? u_hw : u_fw;
		rule_drop = u_hit && (rule_rd_s1[u_hw].act == 8'd0);

		tcp_end = 17'd34 + {11'd0, item_q.header_words, 2'b00};
		small_end = 17'd22 + {11'd0, item_q.header_words, 2'b00};
		sane = (item_q.frame_len >= 16'd34) && (item_q.ether_type == ETYPE_IPV4)
			&& (item_q.ip_version == 4'd4);

		l4r = RSN_CLEAN;
		if (item_q.ip_protocol == PROTO_TCP) begin
			if (tcp_end > {1'b0, item_q.frame_len}) l4r = RSN_L4_SHORT;
			else if (item_q.l4_word[1] && !item_q.l4_word[4]) l4r = RSN_SYN;
			else if (item_q.l4_word[5:0] == 6'd0) l4r = RSN_NULL;
		end else if (item_q.ip_protocol == PROTO_ICMP) begin
			if (small_end > {1'b0, item_q.frame_len}) l4r = RSN_L4_SHORT;
			else if (item_q.l4_word == 16'd8) l4r = RSN_ECHO;
		end else if (item_q.ip_protocol == PROTO_UDP) begin
			if (small_end > {1'b0, item_q.frame_len}) l4r = RSN_L4_SHORT;
			else if (item_q.l4_word == port_a || item_q.l4_word == port_b
				|| item_q.l4_word == port_c || item_q.l4_word == port_d) l4r = RSN_UDP;
		end

		res = '0;
		rate_wr = 1'b0;
		rule_wr = 1'b0;
		if (item_q.func) begin
			rule_wr = u_hit || u_free;
			res.write_ok = rule_wr;
		end else if (!sane) begin
			res.reason = RSN_SANITY;
		end else if (in_window) begin
			res.reason = RSN_RATE;
		end else begin
			rate_wr = 1'b1;
			res.reason = rule_drop ? RSN_RULE : l4r;
		end
		res.verdict = !item_q.func && res.reason != RSN_CLEAN && res.reason != RSN_SANITY
			&& res.reason != RSN_L4_SHORT;
	end

	// Memory writes: clearing sweep or the decide cycle's update.
	always_ff @(posedge clk) begin
		if (ctrl.clear_step) begin
			if (clr_q < CB'(RATE_SETS)) begin
				rate_vmem[clr_q[RSB-1:0]] <= '0;
				for (int k = 0; k < RATE_WAYS; k++) begin
					lru_mem[clr_q[RSB-1:0]][k] <= RWB'(k);
				end
			end
			if (clr_q < CB'(RULE_SETS)) begin
				rule_vmem[clr_q[USB-1:0]] <= '0;
			end
		end else if (ctrl.decide) begin
			if (rate_wr) begin
				rate_mem[rset_q][r_way] <= '{key: item_q.source_addr, stamp: item_q.now_ns};
				rate_vmem[rset_q][r_way] <= 1'b1;
				lru_mem[rset_q] <= lru_new;
			end
			if (rule_wr) begin
				rule_mem[uset_q][u_way] <= '{key: item_q.dest_addr, act: item_q.rule_action_in};
				rule_vmem[uset_q][u_way] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= ctrl.decide;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.decide) begin
			result <= res;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.write_ok |-> !result.verdict)
		else $error("write with drop verdict");
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(ctrl.decide))
		else $error("result without decide");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.decide && in_window |-> !rate_wr)
		else $error("rate refresh inside window");

endmodule

[rtl/core/packet_filter_rate_limiter_top.sv]
// Channel  | Direction | Handshake                 | Word
// item     | in        | start and !busy           | item (pfrl_pkg::item_t)
// result   | out       | done strobe, one cycle    | result (pfrl_pkg::result_t)
// config   | in        | cfg_valid and cfg_ready   | cfg_index, cfg_data
//
// An accepted item reads its rate and rule table rows in the next cycle and is
// decided, together with the update of the same rows, in the cycle after that.
// Done is registered from the decide state, and busy drops in the same cycle
// that done is high, so a new item is taken only once the last one is done.
// After reset the block sweeps every set of both tables to clear the valid bits
// and LRU order; busy stays high during that sweep.
// The receiver cannot stall: done is a one-cycle strobe.
// Configuration writes are accepted in every cycle.
module packet_filter_rate_limiter_top #(
	parameter int RATE_SETS = 1024,
	parameter int RATE_WAYS = 4,
	parameter int RULE_SETS = 256,
	parameter int RULE_WAYS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pfrl_pkg::item_t   item,
	output logic              done,
	output pfrl_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);
	import pfrl_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	logic [39:0] window_q;
	logic [15:0] port_a_q, port_b_q, port_c_q, port_d_q;

	assign cfg_ready = 1'b1;

	// Configuration registers, reset to their documented defaults.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 40'd1000000000;
			port_a_q <= 16'd53;
			port_b_q <= 16'd161;
			port_c_q <= 16'd123;
			port_d_q <= 16'd137;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WINDOW: window_q <= cfg_data[39:0];
				CFG_PORT_A: port_a_q <= cfg_data[15:0];
				CFG_PORT_B: port_b_q <= cfg_data[15:0];
				CFG_PORT_C: port_c_q <= cfg_data[15:0];
				CFG_PORT_D: port_d_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	pfrl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.ctrl  (ctrl)
	);

	pfrl_datapath #(
		.RATE_SETS(RATE_SETS),
		.RATE_WAYS(RATE_WAYS),
		.RULE_SETS(RULE_SETS),
		.RULE_WAYS(RULE_WAYS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.item        (item),
		.window      (window_q),
		.port_a      (port_a_q),
		.port_b      (port_b_q),
		.port_c      (port_c_q),
		.port_d      (port_d_q),
		.result_valid(done),
		.result      (result)
	);

endmodule
